>>> rtl/ray_box_slab_test_core_assert.svh
// Assertion macros for the ray box slab test core
`ifndef RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBS_ASSERT(label, clk, rst_n, prop, msg)
`define RBS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/rbs_pkg.sv
// Shared types and constants for the ray box slab test
package rbs_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned AxisN = 3;
  localparam int unsigned QuotW = 64;
  localparam int unsigned InDataW = 12 * CoordW;
  localparam int unsigned OutDataW = 40;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [QuotW-1:0] quot_t;

  typedef struct packed {
    quot_t near;
    quot_t far;
  } span_t;
endpackage

>>> rtl/rbs_div.sv
// Pipelined signed restoring divider, one quotient bit per stage
module rbs_div #(
  parameter int unsigned NumW = 44,
  parameter int unsigned DenW = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic signed [NumW-1:0]      num_i,
  input  logic signed [DenW-1:0]      den_i,
  output logic signed [NumW:0]        quot_o
);
  localparam int unsigned Stages = NumW;

  logic [NumW-1:0] rem_q [Stages+1];
  logic [NumW-1:0] qt_q  [Stages+1];
  logic [DenW-1:0] den_q [Stages+1];
  logic            neg_q [Stages+1];
  logic [NumW-1:0] rem_d [Stages];
  logic [NumW-1:0] qt_d  [Stages];
  logic [NumW-1:0] anum;
  logic [DenW-1:0] aden;
  logic [NumW:0]   mag;

  assign anum = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign aden = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      qt_q[0]  <= anum;
      den_q[0] <= aden;
      neg_q[0] <= num_i[NumW-1] ^ den_i[DenW-1];
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NumW:0] trial;
    logic [NumW:0] shifted;
    always_comb begin
      shifted = {rem_q[s], qt_q[s][NumW-1]};
      trial   = shifted - (NumW+1)'(den_q[s]);
      if (!trial[NumW]) begin
        rem_d[s] = trial[NumW-1:0];
        qt_d[s]  = {qt_q[s][NumW-2:0], 1'b1};
      end else begin
        rem_d[s] = shifted[NumW-1:0];
        qt_d[s]  = {qt_q[s][NumW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d[s];
        qt_q[s+1]  <= qt_d[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign mag    = {1'b0, qt_q[Stages]};
  assign quot_o = neg_q[Stages] ? $signed(-mag) : $signed(mag);

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule

>>> rtl/rbs_axis.sv
// Per-axis slab: offsets, two pipelined divisions, ordered quotients
module rbs_axis #(
  parameter int unsigned FracBits = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rbs_pkg::coord_t org_i,
  input  rbs_pkg::coord_t dir_i,
  input  rbs_pkg::coord_t lo_i,
  input  rbs_pkg::coord_t hi_i,
  output rbs_pkg::span_t  span_o
);
  import rbs_pkg::*;
  localparam int unsigned NumW = CoordW + FracBits;

  coord_t off_lo_q, off_hi_q, dir_q;
  logic signed [NumW-1:0] num_lo, num_hi;
  logic signed [NumW:0] q_lo, q_hi;
  quot_t ql, qh;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off_lo_q <= lo_i - org_i;
      off_hi_q <= hi_i - org_i;
      dir_q    <= (dir_i == '0) ? coord_t'(1) : dir_i;
    end
  end

  assign num_lo = {off_lo_q, {FracBits{1'b0}}};
  assign num_hi = {off_hi_q, {FracBits{1'b0}}};

  rbs_div #(.NumW(NumW), .DenW(CoordW)) u_div_lo (
    .clk_i, .rst_ni, .en_i, .num_i(num_lo), .den_i(dir_q), .quot_o(q_lo)
  );
  rbs_div #(.NumW(NumW), .DenW(CoordW)) u_div_hi (
    .clk_i, .rst_ni, .en_i, .num_i(num_hi), .den_i(dir_q), .quot_o(q_hi)
  );

  assign ql = QuotW'(q_lo);
  assign qh = QuotW'(q_hi);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      span_o.near <= (ql > qh) ? qh : ql;
      span_o.far  <= (ql > qh) ? ql : qh;
    end
  end
endmodule

>>> rtl/ray_box_slab_test_core.sv
// Top level of the ray box slab test core
// One ray/box test per cycle unless the output stalls. Stages: one offset stage, a
// divider input stage and FRAC_BITS + 32 restoring stages (one quotient bit each) per
// slab plane, one ordering stage, one min/max stage and a final min/max stage that is
// the output register. The whole pipeline advances when the output register is free
// or being read.
module ray_box_slab_test_core #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z (32 bits each)
  input  logic [rbs_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // hit (bit 0), near_distance (bits 32:1), zero fill
  output logic [rbs_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready
);
  import rbs_pkg::*;
  localparam int unsigned Lat = FRAC_BITS + CoordW + 4;

  logic en;
  logic [Lat-1:0] vld_q;
  span_t span [AxisN];
  span_t mid_q, fin_q;
  coord_t near_q;
  logic hit_q, out_vld_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar a = 0; a < AxisN; a++) begin : g_axis
    rbs_axis #(.FracBits(FRAC_BITS)) u_axis (
      .clk_i, .rst_ni, .en_i(en),
      .org_i(s_axis_tdata[a*CoordW +: CoordW]),
      .dir_i(s_axis_tdata[(3+a)*CoordW +: CoordW]),
      .lo_i (s_axis_tdata[(6+a)*CoordW +: CoordW]),
      .hi_i (s_axis_tdata[(9+a)*CoordW +: CoordW]),
      .span_o(span[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_q.near <= (span[1].near > span[0].near) ? span[1].near : span[0].near;
      mid_q.far  <= (span[1].far < span[0].far) ? span[1].far : span[0].far;
      fin_q      <= span[2];
      near_q     <= coord_t'((fin_q.near > mid_q.near) ? fin_q.near : mid_q.near);
      hit_q      <= ((fin_q.near > mid_q.near) ? fin_q.near : mid_q.near)
                    <= ((fin_q.far < mid_q.far) ? fin_q.far : mid_q.far)
                    && !((fin_q.far < mid_q.far) ? fin_q.far[QuotW-1] : mid_q.far[QuotW-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-CoordW-1){1'b0}}, near_q, hit_q};

`include "ray_box_slab_test_core_assert.svh"
  `RBS_ASSERT(a_hold, clk_i, rst_ni, !en |=> m_axis_tvalid, "result dropped")
  `RBS_ASSERT(a_adv, clk_i, rst_ni, !s_axis_tready |=> $stable(vld_q), "pipeline moved in stall")
  `RBS_ASSERT_RST(a_rst, clk_i, !rst_ni |=> !m_axis_tvalid, "valid out of reset")
endmodule
